// ----- rtl/sdnl_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the sort-and-unique neighbour list block.
package sdnl_pkg;

  localparam int MAX_LIST = 32;
  localparam int ID_W     = 31;
  localparam int CNT_W    = 6;
  localparam int NUM_W    = $clog2(MAX_LIST + 1);
  localparam int COUNT_MAX = (1 << CNT_W) - 1;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [NUM_W-1:0] num_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

  // What one cell shows to its neighbours.
  typedef struct packed {
    id_t  value;
    logic valid;
    logic greater;
  } cell_link_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage

// ----- rtl/sort_dedup_neighbor_list_top.sv -----
`timescale 1ns / 1ps
// Top level: sorts and deduplicates one neighbour list through a chain of cells.
//
// Input channel (in_valid, in_stall, in_neighbor, in_last_in_list): one id per
// request, one request per cycle while the list is being collected. Each id is
// placed in order in a chain of MAX_LIST cells in the cycle it is accepted;
// repeats are ignored and, once the chain is full, the largest ids are dropped
// and the overflow flag is raised.
// When the id marked last is accepted the chain drains through cell 0, one
// sorted id per cycle while the receiver does not stall, into the output
// register. in_stall is high for the whole drain, which gives one result per
// distinct id (at most MAX_LIST). After the last id is accepted the state
// register enters the drain, and the first result is then loaded into the
// output register; the next list can start once the final result is loaded.
// Output channel (out_valid, out_stall, out_*): each request carries one id,
// the distinct count and the overflow flag; out_last_of_run marks the end.
// A stalled result holds, and the drain pauses until it is taken.
// Synchronous active-low reset empties the chain and the output register.
module sort_dedup_neighbor_list_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [30:0]          in_neighbor,
  input  logic                 in_last_in_list,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [30:0]          out_sorted_id,
  output logic                 out_last_of_run,
  output logic [5:0]           out_unique_count,
  output logic                 out_overflowed
);
  import sdnl_pkg::*;

  state_t     state_r, state_nxt;
  num_t       count_r, count_nxt;
  logic       ovf_r, ovf_nxt;
  logic       out_valid_r, out_valid_nxt;
  id_t        out_id_r;
  logic       out_last_r;
  cnt_t       out_cnt_r;
  logic       out_ovf_r;

  cell_ctrl_t ctrl;
  cell_link_t links [MAX_LIST];
  logic [MAX_LIST-1:0] equal_vec;
  logic [MAX_LIST-1:0] valid_vec;
  logic       in_acc, dup, pop, pop_last;
  cnt_t       cnt_sat;

  localparam cell_link_t HEAD_LINK = '{value: '0, valid: 1'b1, greater: 1'b0};
  localparam cell_link_t TAIL_LINK = '{value: '0, valid: 1'b0, greater: 1'b1};

  for (genvar i = 0; i < MAX_LIST; i++) begin : g_cell
    cell_link_t prev_l, next_l;
    assign prev_l = (i == 0) ? HEAD_LINK : links[(i == 0) ? 0 : i-1];
    assign next_l = (i == MAX_LIST-1) ? TAIL_LINK : links[(i == MAX_LIST-1) ? i : i+1];
    sdnl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .id        (in_neighbor),
      .prev_link (prev_l),
      .next_link (next_l),
      .link      (links[i]),
      .equal     (equal_vec[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign dup      = |equal_vec;
  assign pop      = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign pop_last = pop && !links[1].valid;
  assign ctrl.ins = in_acc && !dup;
  assign ctrl.pop = pop;

  assign cnt_sat = (count_r > num_t'(COUNT_MAX)) ? cnt_t'(COUNT_MAX) : cnt_t'(count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!dup) begin
            if (links[MAX_LIST-1].valid) begin
              ovf_nxt = 1'b1;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end
          if (in_last_in_list) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (pop) begin
          out_valid_nxt = 1'b1;
          if (pop_last) begin
            state_nxt = ST_IDLE;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_id_r   <= links[0].value;
      out_last_r <= pop_last;
      out_cnt_r  <= cnt_sat;
      out_ovf_r  <= ovf_r;
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_id    = out_id_r;
  assign out_last_of_run  = out_last_r;
  assign out_unique_count = out_cnt_r;
  assign out_overflowed   = out_ovf_r;

  // Valid cells always form a prefix of the chain.
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("valid cells do not form a prefix");

  // While collecting, the count tracks the number of occupied cells.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> count_r == num_t'($countones(valid_vec)))
    else $error("distinct count out of step with the chain");

  // A drain always has an id waiting in the head cell.
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> links[0].valid)
    else $error("drain with an empty head cell");

  // After the final id of a list leaves, the chain is empty.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_last |=> valid_vec == '0 && !ovf_r)
    else $error("chain not empty after the final result");

endmodule

// ----- rtl/sdnl_cell.sv -----
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one id and shifts it up or down.
module sdnl_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sdnl_pkg::cell_ctrl_t ctrl,
  input  sdnl_pkg::id_t       id,
  input  sdnl_pkg::cell_link_t prev_link,
  input  sdnl_pkg::cell_link_t next_link,
  output sdnl_pkg::cell_link_t link,
  output logic                equal
);
  import sdnl_pkg::*;

  id_t  value_r, value_nxt;
  logic valid_r, valid_nxt;

  always_comb begin
    link.value   = value_r;
    link.valid   = valid_r;
    link.greater = !valid_r || (value_r > id);
    equal        = valid_r && (value_r == id);
  end

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.pop) begin
      value_nxt = next_link.value;
      valid_nxt = next_link.valid;
    end else if (ctrl.ins && link.greater) begin
      // The new id lands in the first cell above it; cells beyond take their lower neighbour.
      value_nxt = prev_link.greater ? prev_link.value : id;
      valid_nxt = valid_r || prev_link.valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
